### rtl/efpi_pkg.sv
// Package for the EMA-filtered PI frequency control unit.
// Holds the sequencer state type, register indexes and integrator limits.
// No dependencies.
`default_nettype none

package efpi_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TARGET_VOLTAGE = 3'd0;
  localparam logic [2:0] REG_FREQ_MIN_HZ    = 3'd1;
  localparam logic [2:0] REG_FREQ_MAX_HZ    = 3'd2;
  localparam logic [2:0] REG_GAIN_PROP      = 3'd3;
  localparam logic [2:0] REG_GAIN_INT       = 3'd4;
  localparam logic [2:0] REG_AVG_WEIGHT     = 3'd5;
  localparam logic [2:0] REG_VOLTS_PER_CNT  = 3'd6;

  // Reset values of the configuration registers
  localparam logic [19:0] RST_TARGET_VOLTAGE = 20'd327680;
  localparam logic [19:0] RST_FREQ_MIN_HZ    = 20'd24800;
  localparam logic [19:0] RST_FREQ_MAX_HZ    = 20'd100000;
  localparam logic [19:0] RST_GAIN_PROP      = 20'd60000;
  localparam logic [15:0] RST_GAIN_INT       = 16'd50;
  localparam logic [15:0] RST_AVG_WEIGHT     = 16'd328;
  localparam logic [23:0] RST_VOLTS_PER_CNT  = 24'd21441;

  // Integrator: signed Q32.16 hertz
  localparam int unsigned INTEG_W = 48;
  localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_EMA_MUL  = 10'b00_0000_0010,
    S_EMA_UPD  = 10'b00_0000_0100,
    S_VOLT_MUL = 10'b00_0000_1000,
    S_VOLT_UPD = 10'b00_0001_0000,
    S_INT_MUL  = 10'b00_0010_0000,
    S_INT_UPD  = 10'b00_0100_0000,
    S_PROP_MUL = 10'b00_1000_0000,
    S_CMD      = 10'b01_0000_0000,
    S_LIM      = 10'b10_0000_0000
  } state_e;

endpackage

`default_nettype wire

### rtl/ema_filtered_pi_frequency_control_unit.sv
// EMA-filtered PI frequency control unit, top level.
// One request at a time: a new sample is accepted only while the sequencer is
// idle; the sequencer runs four products through one shared signed multiplier
// plus the add steps, then waits until the result register is free.
// Reset (rst_ni low, asynchronous): registers return to defaults, average
// and integrator clear, no result pending.
// Depends on efpi_pkg.
`default_nettype none

module ema_filtered_pi_frequency_control_unit
  import efpi_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [2:0]             cfg_index_i,
  input  wire logic [23:0]            cfg_data_i,
  // sample channel
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] adc_sample_i,
  // result channel
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [19:0]                 freq_command_o,
  output logic [19:0]                 avg_voltage_o,
  output logic                        clamped_o
);

  localparam int unsigned EW = SAMPLE_BITS + 16;  // average width, Q.16 counts
  localparam int unsigned AW = EW + 1;            // multiplier A operand, signed
  localparam int unsigned BW = 25;                // multiplier B operand, signed
  localparam int unsigned PW = AW + BW;           // product width
  localparam int unsigned SW = PW + 2;            // PI sum width

  localparam logic [PW-1:0] EMA_HALF  = PW'(1) << 15;
  localparam logic [PW-1:0] VOLT_HALF = PW'(1) << 23;

  // Saturate a wide sum to the 48-bit integrator range
  function automatic logic [INTEG_W-1:0] sat_integ(input logic [SW-1:0] v);
    logic [INTEG_W-1:0] r;
    if (!v[SW-1] && (|v[SW-2:INTEG_W-1])) begin
      r = INTEG_MAX;
    end else if (v[SW-1] && !(&v[SW-2:INTEG_W-1])) begin
      r = INTEG_MIN;
    end else begin
      r = v[INTEG_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [19:0] target_q, fmin_q, fmax_q, gp_q;
  logic [15:0] gi_q, aw_q;
  logic [23:0] vpc_q;

  // Sequencer and datapath registers
  state_e                 state_q, state_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [EW-1:0]          ema_q, ema_d;
  logic [INTEG_W-1:0]     integ_q, integ_d;
  logic signed [PW-1:0]   prod_q;
  logic [19:0]            volt_q, volt_d;
  logic [20:0]            err_q, err_d;
  logic [SW-1:0]          cmd_q, cmd_d;
  logic                   out_valid_q, out_valid_d;
  logic [19:0]            freq_q;
  logic [19:0]            volt_out_q;
  logic                   clamped_q;

  // Shared multiplier operands
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_d;

  // Step results
  logic [PW-1:0]        ema_rnd, ema_sum, volt_sum;
  logic [PW-25:0]       volt_full;
  logic [SW-1:0]        prod_ext, integ_ext, base_ext, lo_ext, hi_ext, lim;
  logic                 hit, out_free, load_out;
  logic [AW-1:0]        err_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= RST_TARGET_VOLTAGE;
      fmin_q   <= RST_FREQ_MIN_HZ;
      fmax_q   <= RST_FREQ_MAX_HZ;
      gp_q     <= RST_GAIN_PROP;
      gi_q     <= RST_GAIN_INT;
      aw_q     <= RST_AVG_WEIGHT;
      vpc_q    <= RST_VOLTS_PER_CNT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TARGET_VOLTAGE: target_q <= cfg_data_i[19:0];
        REG_FREQ_MIN_HZ:    fmin_q   <= cfg_data_i[19:0];
        REG_FREQ_MAX_HZ:    fmax_q   <= cfg_data_i[19:0];
        REG_GAIN_PROP:      gp_q     <= cfg_data_i[19:0];
        REG_GAIN_INT:       gi_q     <= cfg_data_i[15:0];
        REG_AVG_WEIGHT:     aw_q     <= cfg_data_i[15:0];
        REG_VOLTS_PER_CNT:  vpc_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Select multiplier operands for the current step
  assign err_ext = {{(AW-21){err_q[20]}}, err_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_EMA_MUL: begin
        mul_a = $signed({1'b0, sample_q, 16'b0} - {1'b0, ema_q});
        mul_b = $signed({9'b0, aw_q});
      end
      S_VOLT_MUL: begin
        mul_a = $signed({1'b0, ema_q});
        mul_b = $signed({1'b0, vpc_q});
      end
      S_INT_MUL: begin
        mul_a = $signed(err_ext);
        mul_b = $signed({9'b0, gi_q});
      end
      S_PROP_MUL: begin
        mul_a = $signed(err_ext);
        mul_b = $signed({5'b0, gp_q});
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Average update: round the weighted step and clamp to the count range
  assign ema_rnd = PW'($signed(prod_q + $signed(EMA_HALF)) >>> 16);
  assign ema_sum = {{(PW-EW){1'b0}}, ema_q} + ema_rnd;

  // Voltage: round to Q4.16 volts
  assign volt_sum  = prod_q + VOLT_HALF;
  assign volt_full = volt_sum[PW-1:24];

  // PI sums in the wide signed domain
  assign prod_ext  = {{(SW-PW){prod_q[PW-1]}}, prod_q};
  assign integ_ext = {{(SW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
  assign base_ext  = {{(SW-36){1'b0}}, (21'(fmin_q) + 21'(fmax_q)), 15'b0};
  assign lo_ext    = {{(SW-36){1'b0}}, fmin_q, 16'b0};
  assign hi_ext    = {{(SW-36){1'b0}}, fmax_q, 16'b0};

  // Clamp the command, lower limit tested first
  always_comb begin
    if ($signed(cmd_q) < $signed(lo_ext)) begin
      lim = lo_ext;
    end else if ($signed(cmd_q) > $signed(hi_ext)) begin
      lim = hi_ext;
    end else begin
      lim = cmd_q;
    end
  end
  assign hit      = (lim != cmd_q);
  assign load_out = (state_q == S_LIM) && out_free;

  // Advance the sequencer and compute next datapath values
  always_comb begin
    state_d     = state_q;
    ema_d       = ema_q;
    integ_d     = integ_q;
    volt_d      = volt_q;
    err_d       = err_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EMA_MUL;
        end
      end
      S_EMA_MUL: begin
        state_d = S_EMA_UPD;
      end
      S_EMA_UPD: begin
        if (ema_sum[PW-1]) begin
          ema_d = '0;
        end else if (|ema_sum[PW-2:EW]) begin
          ema_d = '1;
        end else begin
          ema_d = ema_sum[EW-1:0];
        end
        state_d = S_VOLT_MUL;
      end
      S_VOLT_MUL: begin
        state_d = S_VOLT_UPD;
      end
      S_VOLT_UPD: begin
        if (|volt_full[PW-25:20]) begin
          volt_d = '1;
        end else begin
          volt_d = volt_full[19:0];
        end
        err_d   = {1'b0, target_q} - {1'b0, volt_d};
        state_d = S_INT_MUL;
      end
      S_INT_MUL: begin
        state_d = S_INT_UPD;
      end
      S_INT_UPD: begin
        integ_d = sat_integ(integ_ext + prod_ext);
        state_d = S_PROP_MUL;
      end
      S_PROP_MUL: begin
        state_d = S_CMD;
      end
      S_CMD: begin
        cmd_d   = base_ext - (prod_ext + integ_ext);
        state_d = S_LIM;
      end
      S_LIM: begin
        // hold until the result register is free
        if (out_free) begin
          if (hit) begin
            integ_d = sat_integ(integ_ext + (cmd_q - lim));
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ema_q       <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ema_q       <= ema_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= adc_sample_i;
    end
    prod_q <= prod_d;
    volt_q <= volt_d;
    err_q  <= err_d;
    cmd_q  <= cmd_d;
    // hold the result fields while the next request is worked on
    if (load_out) begin
      freq_q     <= lim[35:16];
      volt_out_q <= volt_q;
      clamped_q  <= hit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign freq_command_o = freq_q;
  assign avg_voltage_o  = volt_out_q;
  assign clamped_o      = clamped_q;

  // Accepted request starts the sequence
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EMA_MUL)
    else $error("accepted request did not start the sequence");

  // Final step with a free result slot presents a result
  a_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIM && out_free |=> out_valid_o && in_ready_o)
    else $error("final step did not deliver a result");

  // A clamped command sits on one of the limits
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && hit |=> freq_command_o == $past(fmin_q) || freq_command_o == $past(fmax_q))
    else $error("clamped command is off the limits");

endmodule

`default_nettype wire
